// ----- hdl/lfu_pkg.sv -----
// Shared types and constants for the LFU cache table.
// No dependencies; lfu_unit and lfu_cache_table import this package.
package lfu_pkg;

   localparam int KEY_W        = 32;
   localparam int VAL_W        = 32;
   localparam int COUNT_W      = 32;
   localparam int CSR_W        = 5;
   localparam int CAPACITY_DEF = 16;

   localparam logic [CSR_W-1:0]   CSR_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   typedef struct packed {
      logic                    action;
      logic signed [KEY_W-1:0] search_key;
      logic signed [VAL_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] read_value;
      logic                    evicted;
      logic signed [KEY_W-1:0] evicted_key;
   } rsp_type;

   // What the update sweep does to each entry
   typedef struct packed {
      logic             put;
      logic             hit;
      logic             evict;
      logic             insert;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] wval;
   } upd_ctx_type;

endpackage

// ----- hdl/lfu_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lfu_unit.sv -----
// Shared per-entry compare and update unit of the LFU cache table.
// Depends on lfu_pkg; used once per sweep cycle by lfu_cache_table.
module lfu_unit import lfu_pkg::*; #(
   parameter int IDX_W  = 4,
   parameter int RANK_W = 4
) (
   input  upd_ctx_type        ctx,
   input  logic [IDX_W-1:0]   ent_idx,
   input  logic               ent_valid,
   input  logic [KEY_W-1:0]   ent_key,
   input  logic [VAL_W-1:0]   ent_value,
   input  logic [COUNT_W-1:0] ent_count,
   input  logic [RANK_W-1:0]  ent_rank,
   input  logic               vic_found,
   input  logic [IDX_W-1:0]   vic_idx,
   input  logic [COUNT_W-1:0] vic_count,
   input  logic [RANK_W-1:0]  vic_rank,
   input  logic [IDX_W-1:0]   hit_idx,
   input  logic [RANK_W-1:0]  hit_rank,
   input  logic [IDX_W-1:0]   ins_idx,
   output logic               match,
   output logic               better,
   output logic               free,
   output logic               new_valid,
   output logic [KEY_W-1:0]   new_key,
   output logic [VAL_W-1:0]   new_value,
   output logic [COUNT_W-1:0] new_count,
   output logic [RANK_W-1:0]  new_rank
);

   // Scan compares
   assign match  = ent_valid && (ent_key == ctx.key);
   assign free   = !ent_valid;
   assign better = ent_valid &&
                   (!vic_found || (ent_count < vic_count) ||
                    ((ent_count == vic_count) && (ent_rank > vic_rank)));

   // Update rewrite
   always_comb begin
      new_valid = ent_valid;
      new_key   = ent_key;
      new_value = ent_value;
      new_count = ent_count;
      new_rank  = ent_rank;
      if (ctx.hit) begin
         if (ent_idx == hit_idx) begin
            new_rank  = '0;
            new_count = (ent_count == COUNT_MAX) ? ent_count : ent_count + COUNT_W'(1);
            if (ctx.put) begin
               new_value = ctx.wval;
            end
         end else if (ent_valid && (ent_rank < hit_rank)) begin
            new_rank = ent_rank + RANK_W'(1);
         end
      end else if (ctx.insert) begin
         if (ent_idx == ins_idx) begin
            new_valid = 1'b1;
            new_key   = ctx.key;
            new_value = ctx.wval;
            new_count = COUNT_W'(1);
            new_rank  = '0;
         end else if (ctx.evict && (ent_idx == vic_idx)) begin
            new_valid = 1'b0;
         end else if (ent_valid) begin
            // close the gap left by the victim, then age for the new entry
            if (!(ctx.evict && (ent_rank > vic_rank))) begin
               new_rank = ent_rank + RANK_W'(1);
            end
         end
      end
   end

endmodule

// ----- hdl/lfu_cache_table.sv -----
// LFU cache table with LRU tie break: key/value store of up to CAPACITY entries.
//
// Usage:
//  - req channel (req_valid/req_stall/req_data): one get or put item. It is taken
//    when req_valid is high and req_stall low. req_stall is high while an item
//    is being worked on and during the clearing pass.
//  - rsp channel (rsp_valid/rsp_stall/rsp_data): one result item per request, held
//    in an output register until rsp_stall is low. A new request is taken while
//    an older result still waits there; only the hand-over of the next result
//    waits for the register to drain.
//  - csr_we/csr_wdata write capacity_in_use (reset 16); write only while idle.
// Timing: each item scans the table one entry per cycle through the shared
// compare unit and one RAM read port, then passes a decide state, then,
// unless it is a get miss or a put at capacity zero, an update sweep that
// rewrites every entry.
// Reset: synchronous; a clearing pass then marks every entry invalid, with
// req_stall high meanwhile.
module lfu_cache_table import lfu_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RANK_W = IDX_W;
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (FILL_W > CSR_W) ? FILL_W : CSR_W;
   localparam int ENT_W  = 1 + KEY_W + VAL_W + COUNT_W + RANK_W;

   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [FILL_W-1:0] CAP_CNT  = FILL_W'(CAPACITY);
   localparam logic [CMP_W-1:0]  CAP_CMP  = CMP_W'(CAPACITY);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_DONE   = 6'b100000
   } fsm_type;

   // control state
   fsm_type           fsm_ff, fsm_in;
   logic [FILL_W-1:0] cnt_ff, cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CSR_W-1:0]  csr_ff, csr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // item and scan results
   req_type            item_ff, item_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0]  hit_rank_ff, hit_rank_in;
   logic [VAL_W-1:0]   hit_value_ff, hit_value_in;
   logic               vic_ff, vic_in;
   logic [IDX_W-1:0]   vic_idx_ff, vic_idx_in;
   logic [COUNT_W-1:0] vic_count_ff, vic_count_in;
   logic [RANK_W-1:0]  vic_rank_ff, vic_rank_in;
   logic [KEY_W-1:0]   vic_key_ff, vic_key_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               full_ff, full_in;

   // RAM port
   logic             ram_we, ram_re;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [ENT_W-1:0] ram_wdata, ram_rdata;

   logic               rd_valid;
   logic [KEY_W-1:0]   rd_key;
   logic [VAL_W-1:0]   rd_value;
   logic [COUNT_W-1:0] rd_count;
   logic [RANK_W-1:0]  rd_rank;

   logic               u_match, u_better, u_free;
   logic               nw_valid;
   logic [KEY_W-1:0]   nw_key;
   logic [VAL_W-1:0]   nw_value;
   logic [COUNT_W-1:0] nw_count;
   logic [RANK_W-1:0]  nw_rank;

   upd_ctx_type      ctx;
   logic             cap_zero, table_full, issue, rsp_load;
   logic [CMP_W-1:0] cap_eff;
   logic [IDX_W-1:0] ins_idx;

   assign {rd_valid, rd_key, rd_value, rd_count, rd_rank} = ram_rdata;

   lfu_ram #(
      .WIDTH (ENT_W),
      .DEPTH (CAPACITY),
      .ADDR_W(IDX_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   lfu_unit #(
      .IDX_W (IDX_W),
      .RANK_W(RANK_W)
   ) u_unit (
      .ctx      (ctx),
      .ent_idx  (rd_idx_ff),
      .ent_valid(rd_valid),
      .ent_key  (rd_key),
      .ent_value(rd_value),
      .ent_count(rd_count),
      .ent_rank (rd_rank),
      .vic_found(vic_ff),
      .vic_idx  (vic_idx_ff),
      .vic_count(vic_count_ff),
      .vic_rank (vic_rank_ff),
      .hit_idx  (hit_idx_ff),
      .hit_rank (hit_rank_ff),
      .ins_idx  (ins_idx),
      .match    (u_match),
      .better   (u_better),
      .free     (u_free),
      .new_valid(nw_valid),
      .new_key  (nw_key),
      .new_value(nw_value),
      .new_count(nw_count),
      .new_rank (nw_rank)
   );

   // Effective capacity: the register clipped to the table size
   assign cap_zero   = (csr_ff == '0);
   assign cap_eff    = (CMP_W'(csr_ff) > CAP_CMP) ? CAP_CMP : CMP_W'(csr_ff);
   assign table_full = (CMP_W'(fill_ff) >= cap_eff);

   // Decision from the finished scan; stable through the update sweep.
   // The full flag is taken at the end of the scan, before fill moves.
   always_comb begin
      ctx.put    = (item_ff.action == ACT_PUT);
      ctx.key    = item_ff.search_key;
      ctx.wval   = item_ff.write_value;
      ctx.hit    = hit_ff && !(ctx.put && cap_zero);
      ctx.evict  = ctx.put && !cap_zero && !hit_ff && full_ff && vic_ff;
      ctx.insert = ctx.put && !cap_zero && !hit_ff && (free_ff || ctx.evict);
   end

   // Insert into the first free slot once the victim is gone
   assign ins_idx = (ctx.evict && (!free_ff || (vic_idx_ff < free_idx_ff))) ?
                    vic_idx_ff : free_idx_ff;

   assign issue    = (cnt_ff < CAP_CNT);
   assign rsp_load = (fsm_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      fsm_in       = fsm_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = cnt_ff[IDX_W-1:0];
      fill_in      = fill_ff;
      csr_in       = csr_we ? csr_wdata : csr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      item_in      = item_ff;
      rsp_data_in  = rsp_data_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      hit_value_in = hit_value_ff;
      vic_in       = vic_ff;
      vic_idx_in   = vic_idx_ff;
      vic_count_in = vic_count_ff;
      vic_rank_in  = vic_rank_ff;
      vic_key_in   = vic_key_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      full_in      = full_ff;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff[IDX_W-1:0];
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = cnt_ff[IDX_W-1:0];

      case (fsm_ff)
         ST_CLEAR: begin
            // write an invalid entry at every address
            ram_we = 1'b1;
            cnt_in = cnt_ff + FILL_W'(1);
            if (cnt_ff[IDX_W-1:0] == LAST_IDX) begin
               cnt_in = '0;
               fsm_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               cnt_in  = '0;
               hit_in  = 1'b0;
               vic_in  = 1'b0;
               free_in = 1'b0;
               fsm_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               ram_re    = 1'b1;
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + FILL_W'(1);
            end
            if (rd_vld_ff) begin
               if (u_match && !hit_ff) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_rank_in  = rd_rank;
                  hit_value_in = rd_value;
               end
               if (u_better) begin
                  vic_in       = 1'b1;
                  vic_idx_in   = rd_idx_ff;
                  vic_count_in = rd_count;
                  vic_rank_in  = rd_rank;
                  vic_key_in   = rd_key;
               end
               if (u_free && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  full_in = table_full;
                  fsm_in  = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            cnt_in = '0;
            fsm_in = (ctx.hit || ctx.insert) ? ST_UPDATE : ST_DONE;
         end
         ST_UPDATE: begin
            if (issue) begin
               ram_re    = 1'b1;
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + FILL_W'(1);
            end
            if (rd_vld_ff) begin
               // write back the entry read last cycle
               ram_we    = 1'b1;
               ram_waddr = rd_idx_ff;
               ram_wdata = {nw_valid, nw_key, nw_value, nw_count, nw_rank};
               if (rd_idx_ff == LAST_IDX) begin
                  fill_in = fill_ff - (ctx.evict ? FILL_W'(1) : '0)
                                    + (ctx.insert ? FILL_W'(1) : '0);
                  fsm_in  = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_data_in.hit         = ctx.hit;
               rsp_data_in.read_value  = (!ctx.put && hit_ff) ? hit_value_ff : '0;
               rsp_data_in.evicted     = ctx.evict;
               rsp_data_in.evicted_key = ctx.evict ? vic_key_ff : '0;
               rsp_valid_in            = 1'b1;
               fsm_in                  = ST_IDLE;
            end
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_CLEAR;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         fill_ff      <= '0;
         csr_ff       <= CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         fill_ff      <= fill_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      item_ff      <= item_in;
      rsp_data_ff  <= rsp_data_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      hit_value_ff <= hit_value_in;
      vic_ff       <= vic_in;
      vic_idx_ff   <= vic_idx_in;
      vic_count_ff <= vic_count_in;
      vic_rank_ff  <= vic_rank_in;
      vic_key_ff   <= vic_key_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      full_ff      <= full_in;
   end

   assign req_stall = (fsm_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // fill never exceeds the table size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_CNT)
      else $error("fill count above table size");

   // RAM read data only arrives during a sweep
   a_rd_in_sweep: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (fsm_ff == ST_SCAN || fsm_ff == ST_UPDATE))
      else $error("read data outside a sweep");

   // a hit never also inserts
   a_hit_no_insert: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == ST_UPDATE) |-> !(ctx.hit && ctx.insert))
      else $error("hit and insert together");

   // an eviction needs a non-empty table
   a_evict_fill: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == ST_UPDATE && ctx.evict) |-> (fill_ff != '0))
      else $error("eviction from an empty table");

   // a loaded result is presented next cycle
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("result lost at load");

endmodule
